>>> rtl/pal_pkg.sv
// Package for the positional array list unit: field widths, operation and
// status codes, and the result and sequencer status structs.
// No dependencies.
`timescale 1ns / 1ps

package pal_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int MODE_W       = 2;
  localparam int POS_W        = 9;
  localparam int WORD_W       = 32;
  localparam int STAT_W       = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FIND   = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   found_pos;
    logic [POS_W-1:0]   length;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
    res_t res;
  } ctl_stat_t;

endpackage

>>> rtl/pal_store.sv
// Element store of the positional array list: one write port and one read
// port with registered read data. Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_store #(
  parameter int DEPTH = pal_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr_i,
  input  logic [pal_pkg::WORD_W-1:0]     wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr_i,
  output logic [pal_pkg::WORD_W-1:0]     rd_data_o
);
  import pal_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/pal_ctrl.sv
// Sequencer of the positional array list: checks positions, walks the store
// one entry per cycle to shift or search, and keeps the entry count.
// Depends on pal_pkg; drives the ports of pal_store.
`timescale 1ns / 1ps

module pal_ctrl #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pal_pkg::MODE_W-1:0]        mode_i,
  input  logic [pal_pkg::POS_W-1:0]         pos_i,
  input  logic [pal_pkg::WORD_W-1:0]        value_i,
  input  logic                              res_ready_i,
  output pal_pkg::ctl_stat_t                stat_o,
  output logic                              wr_en_o,
  output logic [$clog2(CAPACITY)-1:0]       wr_addr_o,
  output logic [pal_pkg::WORD_W-1:0]        wr_data_o,
  output logic [$clog2(CAPACITY)-1:0]       rd_addr_o,
  input  logic [pal_pkg::WORD_W-1:0]        rd_data_i
);
  import pal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int WW = (CW > POS_W) ? CW : POS_W;
  localparam int XW = WW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_LAST,
    S_INS_PUT,
    S_DEL_WALK,
    S_DEL_LAST,
    S_FIND_WALK,
    S_RESP
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     cnt_q;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     stop_q;
  logic              pend_q;
  logic [AW-1:0]     pend_addr_q;
  logic [WORD_W-1:0] word_q;
  status_e           status_q;
  logic [POS_W-1:0]  where_q;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_m1_x;
  logic [XW-1:0] where_x;
  logic [CW-1:0] cnt_m1;
  logic          ins_bad;
  logic          del_bad;
  logic          is_full;
  logic          is_match;

  assign pos_x    = {{(XW-POS_W){1'b0}}, pos_i};
  assign cnt_x    = {{(XW-CW){1'b0}}, cnt_q};
  assign pos_m1_x = pos_x - XW'(1);
  assign cnt_m1   = cnt_q - CW'(1);
  assign where_x  = {{(XW-AW){1'b0}}, pend_addr_q} + XW'(1);
  assign ins_bad  = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
  assign del_bad  = (pos_x == '0) || (pos_x > cnt_x);
  assign is_full  = (cnt_x >= XW'(CAPACITY));
  assign is_match = (rd_data_i == word_q);

  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = pend_addr_q;
    wr_data_o = rd_data_i;
    case (state_q)
      S_INS_WALK, S_INS_LAST, S_DEL_WALK, S_DEL_LAST: begin
        wr_en_o = pend_q;
      end
      S_INS_PUT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = stop_q;
        wr_data_o = word_q;
      end
      default: begin
        wr_en_o = 1'b0;
      end
    endcase
  end

  assign rd_addr_o = addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      status_q    <= ST_OK;
      where_q     <= '0;
      addr_q      <= '0;
      stop_q      <= '0;
      pend_addr_q <= '0;
      word_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          pend_q <= 1'b0;
          if (start_i) begin
            status_q <= ST_OK;
            where_q  <= '0;
            word_q   <= value_i;
            state_q  <= S_RESP;
            case (mode_i)
              MODE_INSERT: begin
                if (ins_bad) begin
                  status_q <= ST_BAD_POS;
                end else if (is_full) begin
                  status_q <= ST_FULL;
                end else begin
                  stop_q <= pos_m1_x[AW-1:0];
                  addr_q <= cnt_m1[AW-1:0];
                  if (pos_m1_x == cnt_x) begin
                    state_q <= S_INS_PUT;
                  end else begin
                    state_q <= S_INS_WALK;
                  end
                end
              end
              MODE_DELETE: begin
                if (del_bad) begin
                  status_q <= ST_BAD_POS;
                end else if (pos_x == cnt_x) begin
                  cnt_q <= cnt_m1;
                end else begin
                  addr_q  <= pos_x[AW-1:0];
                  stop_q  <= cnt_m1[AW-1:0];
                  state_q <= S_DEL_WALK;
                end
              end
              MODE_FIND: begin
                if (cnt_q == '0) begin
                  status_q <= ST_NOT_FOUND;
                end else begin
                  addr_q  <= '0;
                  stop_q  <= cnt_m1[AW-1:0];
                  state_q <= S_FIND_WALK;
                end
              end
              default: begin
                status_q <= ST_OK;
              end
            endcase
          end
        end
        S_INS_WALK: begin
          pend_q      <= 1'b1;
          pend_addr_q <= addr_q + AW'(1);
          if (addr_q == stop_q) begin
            state_q <= S_INS_LAST;
          end else begin
            addr_q <= addr_q - AW'(1);
          end
        end
        S_INS_LAST: begin
          pend_q  <= 1'b0;
          state_q <= S_INS_PUT;
        end
        S_INS_PUT: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= S_RESP;
        end
        S_DEL_WALK: begin
          pend_q      <= 1'b1;
          pend_addr_q <= addr_q - AW'(1);
          if (addr_q == stop_q) begin
            state_q <= S_DEL_LAST;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        S_DEL_LAST: begin
          pend_q  <= 1'b0;
          cnt_q   <= cnt_m1;
          state_q <= S_RESP;
        end
        S_FIND_WALK: begin
          if (pend_q && is_match) begin
            pend_q   <= 1'b0;
            status_q <= ST_OK;
            where_q  <= where_x[POS_W-1:0];
            state_q  <= S_RESP;
          end else if (pend_q && (pend_addr_q == stop_q)) begin
            pend_q   <= 1'b0;
            status_q <= ST_NOT_FOUND;
            state_q  <= S_RESP;
          end else begin
            pend_q      <= 1'b1;
            pend_addr_q <= addr_q;
            if (addr_q != stop_q) begin
              addr_q <= addr_q + AW'(1);
            end
          end
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign stat_o.idle          = (state_q == S_IDLE);
  assign stat_o.done          = (state_q == S_RESP);
  assign stat_o.res.status    = status_q;
  assign stat_o.res.found_pos = where_q;
  assign stat_o.res.length    = cnt_x[POS_W-1:0];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_wr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> ({{(XW-AW){1'b0}}, wr_addr_o} <= cnt_x))
    else $error("Store write lands beyond the end of the list.");

  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_PUT |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("Insert did not grow the list by one entry.");

  a_del_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEL_LAST |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("Delete did not shrink the list by one entry.");

endmodule

>>> rtl/positional_array_list_unit.sv
// Top level of the positional array list unit: input handshake, result
// register and the sequencer with its element store.
// Depends on pal_pkg, pal_store and pal_ctrl.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+------------------------------------
//   in      | input     | in_valid_i/in_stall_o   | mode_i, position_i, value_i
//   out     | output    | out_valid_o/out_stall_i | status_o, found_position_o, length_o
//
// An insert at position p shifts the entries from the end back to p, a delete
// shifts those behind p forward and a find walks from the front up to a match,
// one entry per cycle, over the store with its one write and one read port.
// Reset clears the entry count but not the store; the store needs no clearing pass.
// A new transaction is taken once the sequencer is idle, also while the last
// result still waits in the output register under out_stall_i.
`timescale 1ns / 1ps

module positional_array_list_unit #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pal_pkg::MODE_W-1:0]          mode_i,
  input  logic [pal_pkg::POS_W-1:0]           position_i,
  input  logic signed [pal_pkg::WORD_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pal_pkg::STAT_W-1:0]          status_o,
  output logic [pal_pkg::POS_W-1:0]           found_position_o,
  output logic [pal_pkg::POS_W-1:0]           length_o
);
  import pal_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  ctl_stat_t          ctl_stat;
  logic               start;
  logic               res_ready;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  rd_data;
  logic               out_valid_q;
  res_t               out_res_q;

  assign in_stall_o = !ctl_stat.idle;
  assign start      = in_valid_i && !in_stall_o;
  assign res_ready  = !out_valid_q || !out_stall_i;

  pal_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .mode_i      (mode_i),
    .pos_i       (position_i),
    .value_i     (value_i),
    .res_ready_i (res_ready),
    .stat_o      (ctl_stat),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  pal_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_stat.done && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_stat.done && res_ready) begin
      out_res_q <= ctl_stat.res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign found_position_o = out_res_q.found_pos;
  assign length_o         = out_res_q.length;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for positional_array_list_unit: a queue-fed driver and a
// monitor on the valid/stall channels, checked against a queue-based model of the list.
// Depends on pal_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_top;
  import pal_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_POS = (1 << POS_W) - 1;

  typedef struct {
    logic [MODE_W-1:0]        op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
  } list_op_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [MODE_W-1:0]        mode_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [WORD_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic [POS_W-1:0]         found_position_o;
  logic [POS_W-1:0]         length_o;

  list_op_t                 op_backlog[$];
  list_op_t                 next_op;
  res_t                     awaited_results[$];
  res_t                     want;
  logic signed [WORD_W-1:0] held_words[$];
  int                       shadow_len = 0;
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;
  int                       error_count = 0;

  positional_array_list_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .length_o        (length_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic res_t apply_list_op(input logic [MODE_W-1:0] op,
                                         input logic [POS_W-1:0] pos,
                                         input logic signed [WORD_W-1:0] word);
    res_t r;
    int   cnt;
    int   k;
    r.status = ST_OK;
    r.found_pos = '0;
    cnt = held_words.size();
    case (op)
      MODE_INSERT: begin
        if (pos < 1 || pos > cnt + 1) r.status = ST_BAD_POS;
        else if (cnt >= CAPACITY) r.status = ST_FULL;
        else held_words.insert(pos - 1, word);
      end
      MODE_DELETE: begin
        if (pos < 1 || pos > cnt) r.status = ST_BAD_POS;
        else held_words.delete(pos - 1);
      end
      MODE_FIND: begin
        for (k = 0; k < cnt && r.found_pos == '0; k++) begin
          if (held_words[k] == word) r.found_pos = POS_W'(k + 1);
        end
        if (r.found_pos == '0) r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.length = POS_W'(held_words.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic add_item(input logic [MODE_W-1:0] op, input int pos,
                          input logic signed [WORD_W-1:0] word);
    list_op_t it;
    it.op = op;
    it.pos = POS_W'(pos);
    it.word = word;
    op_backlog.push_back(it);
    case (op)
      MODE_INSERT: if (pos >= 1 && pos <= shadow_len + 1 && shadow_len < CAPACITY) shadow_len++;
      MODE_DELETE: if (pos >= 1 && pos <= shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  function automatic int pick_position(input int top);
    int roll;
    roll = $urandom_range(99);
    if (top >= 1 && roll < 85) begin
      if (roll < 20) return 1;
      if (roll < 40) return top;
      return $urandom_range(top, 1);
    end
    if (roll % 2 == 0) return 0;
    return $urandom_range(MAX_POS, top + 1);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    if ($urandom_range(99) < 55) return $urandom;
    case ($urandom_range(7))
      0: return 32'sh0000_0000;
      1: return 32'sh0000_0001;
      2: return 32'shFFFF_FFFF;
      3: return 32'sh8000_0000;
      4: return 32'sh7FFF_FFFF;
      5: return 32'sh0000_FFFF;
      6: return 32'shA5A5_A5A5;
      default: return 32'sh5A5A_5A5A;
    endcase
  endfunction

  task automatic add_random_item(input bit filling);
    int               roll;
    logic [MODE_W-1:0] op;
    roll = $urandom_range(99);
    if (filling)
      op = roll < 70 ? MODE_INSERT : roll < 82 ? MODE_DELETE : roll < 97 ? MODE_FIND : MODE_UNUSED;
    else
      op = roll < 20 ? MODE_INSERT : roll < 75 ? MODE_DELETE : roll < 97 ? MODE_FIND : MODE_UNUSED;
    case (op)
      MODE_INSERT: add_item(op, pick_position(shadow_len + 1), pick_word());
      MODE_DELETE: add_item(op, pick_position(shadow_len), pick_word());
      default:     add_item(op, $urandom_range(MAX_POS), pick_word());
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (op_backlog.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= '0;
      position_i <= '0;
      value_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o)
        awaited_results.push_back(apply_list_op(mode_i, position_i, value_i));
      if (!in_valid_i || !in_stall_o) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = op_backlog.pop_front();
          mode_i <= next_op.op;
          position_i <= next_op.pos;
          value_i <= next_op.word;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transaction with no expectation outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (found_position_o !== want.found_pos)
            report_mismatch($sformatf("found_position %0d, expected %0d",
                                      found_position_o, want.found_pos));
          if (length_o !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d", length_o, want.length));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    bit filling;
    int bound_hits;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list, bad positions, insert at front, middle and end, duplicates,
    // first-match find, misses, the unused mode and deletes at both ends.
    add_item(MODE_FIND, 0, 32'sh0000_0000);
    add_item(MODE_DELETE, 1, 32'sh0000_0000);
    add_item(MODE_DELETE, 0, 32'sh0000_0000);
    add_item(MODE_INSERT, 0, 32'sh1234_5678);
    add_item(MODE_INSERT, 2, 32'sh1234_5678);
    add_item(MODE_INSERT, 1, 32'sh8000_0000);
    add_item(MODE_INSERT, 2, 32'sh7FFF_FFFF);
    add_item(MODE_INSERT, 1, 32'shFFFF_FFFF);
    add_item(MODE_INSERT, 2, 32'sh0000_0000);
    add_item(MODE_INSERT, MAX_POS, 32'sh0000_0001);
    add_item(MODE_INSERT, 5, 32'sh7FFF_FFFF);
    add_item(MODE_FIND, MAX_POS, 32'sh7FFF_FFFF);
    add_item(MODE_FIND, 0, 32'sh8000_0000);
    add_item(MODE_FIND, 3, 32'sh0000_3039);
    add_item(MODE_UNUSED, MAX_POS, 32'shFFFF_FFFF);
    add_item(MODE_DELETE, 6, 32'sh0000_0000);
    add_item(MODE_DELETE, MAX_POS, 32'sh0000_0000);
    add_item(MODE_DELETE, 5, 32'sh0000_0000);
    add_item(MODE_DELETE, 1, 32'sh0000_0000);
    add_item(MODE_FIND, 1, 32'shFFFF_FFFF);
    add_item(MODE_DELETE, 2, 32'sh0000_0000);
    add_item(MODE_FIND, 2, 32'sh0000_0000);
    add_item(MODE_UNUSED, 0, 32'sh0000_0000);
    wait_drained();

    filling = 1'b1;
    bound_hits = 0;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 69; end
        3: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (n = 0; n < 212; n++) begin
        if ((filling && shadow_len == CAPACITY) || (!filling && shadow_len == 0)) bound_hits++;
        if (bound_hits >= 12) begin
          filling = !filling;
          bound_hits = 0;
        end
        add_random_item(filling);
      end
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
